@@ rtl/nearest_seed_region_labeler_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-seed region labeler
// Shared implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SEED_REGION_LABELER_TOP_ASSERT_SVH
`define NEAREST_SEED_REGION_LABELER_TOP_ASSERT_SVH

// same-cycle implication
`define NSRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NSRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/nsrl_pkg.sv @@
// ----------------------------------------------------------------------------
// nsrl_pkg
// Types and constants of the nearest-seed region labeler.
// ----------------------------------------------------------------------------
`default_nettype none

package nsrl_pkg;

	localparam int COORD_W  = 12;
	localparam int REGION_W = 8;
	localparam int SLOT_W   = 6;
	localparam int SQ_W     = 2 * COORD_W;
	localparam int DIST_W   = SQ_W + 1;
	localparam int CNT_W    = 7;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_IDX_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

	typedef struct packed {
		logic                func;
		logic [SLOT_W-1:0]   slot;
		logic [COORD_W-1:0]  pos_x;
		logic [COORD_W-1:0]  pos_y;
		logic [REGION_W-1:0] seed_region;
	} in_t;

	typedef struct packed {
		logic [REGION_W-1:0] region_out;
		logic [COORD_W-1:0]  pixel_x;
		logic [COORD_W-1:0]  pixel_y;
	} out_t;

	typedef struct packed {
		logic                valid;
		logic                func;
		logic [SLOT_W-1:0]   slot;
		logic [COORD_W-1:0]  pos_x;
		logic [COORD_W-1:0]  pos_y;
		logic [REGION_W-1:0] region;
		logic [DIST_W-1:0]   best_dist;
		logic [REGION_W-1:0] best_region;
	} pipe_t;

endpackage

`default_nettype wire

@@ rtl/nsrl_cell.sv @@
// ----------------------------------------------------------------------------
// nsrl_cell
// One seed slot: holds its seed, squares the offsets to the passing pixel,
// then folds the distance into the running nearest match.
// ----------------------------------------------------------------------------
`default_nettype none

module nsrl_cell #(
	parameter int K = 0
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 adv,
	input  wire  [nsrl_pkg::CNT_W-1:0]          count,
	input  nsrl_pkg::pipe_t                     pipe_in,
	output nsrl_pkg::pipe_t                     pipe_out
);
	import nsrl_pkg::*;

	logic [COORD_W-1:0]  seed_x_q;
	logic [COORD_W-1:0]  seed_y_q;
	logic [REGION_W-1:0] seed_r_q;

	pipe_t               item_s1;
	logic [SQ_W-1:0]     sq_x_s1;
	logic [SQ_W-1:0]     sq_y_s1;
	logic [REGION_W-1:0] sreg_s1;
	pipe_t               item_s2;

	logic [COORD_W-1:0]  dx;
	logic [COORD_W-1:0]  dy;
	logic [DIST_W-1:0]   dist_sum;
	logic                take;
	logic                load_hit;

	assign load_hit = adv && pipe_in.valid && (pipe_in.func == FUNC_LOAD)
		&& (int'(pipe_in.slot) == K);

	assign dx = (pipe_in.pos_x >= seed_x_q) ? pipe_in.pos_x - seed_x_q
		: seed_x_q - pipe_in.pos_x;
	assign dy = (pipe_in.pos_y >= seed_y_q) ? pipe_in.pos_y - seed_y_q
		: seed_y_q - pipe_in.pos_y;

	assign dist_sum = DIST_W'(sq_x_s1) + DIST_W'(sq_y_s1);
	assign take = (K == 0) || ((K < int'(count)) && (dist_sum < item_s1.best_dist));

	always_ff @(posedge clk) begin
		if (load_hit) begin
			seed_x_q <= pipe_in.pos_x;
			seed_y_q <= pipe_in.pos_y;
			seed_r_q <= pipe_in.region;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			sq_x_s1 <= '0;
			sq_y_s1 <= '0;
			sreg_s1 <= '0;
			item_s2 <= '0;
		end else if (adv) begin
			item_s1.valid       <= pipe_in.valid;
			item_s1.func        <= pipe_in.func;
			item_s1.slot        <= pipe_in.slot;
			item_s1.pos_x       <= pipe_in.pos_x;
			item_s1.pos_y       <= pipe_in.pos_y;
			item_s1.region      <= pipe_in.region;
			item_s1.best_dist   <= pipe_in.best_dist;
			item_s1.best_region <= pipe_in.best_region;
			sq_x_s1             <= dx * dx;
			sq_y_s1             <= dy * dy;
			sreg_s1             <= seed_r_q;

			item_s2.valid       <= item_s1.valid;
			item_s2.func        <= item_s1.func;
			item_s2.slot        <= item_s1.slot;
			item_s2.pos_x       <= item_s1.pos_x;
			item_s2.pos_y       <= item_s1.pos_y;
			item_s2.region      <= item_s1.region;
			item_s2.best_dist   <= take ? dist_sum : item_s1.best_dist;
			item_s2.best_region <= take ? sreg_s1 : item_s1.best_region;
		end
	end

	assign pipe_out = item_s2;

endmodule

`default_nettype wire

@@ rtl/nsrl_cfg.sv @@
// ----------------------------------------------------------------------------
// nsrl_cfg
// APB register block holding the searched seed count.
// ----------------------------------------------------------------------------
`default_nettype none

module nsrl_cfg (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [nsrl_pkg::ADDR_W-1:0]   paddr,
	input  wire  [nsrl_pkg::DATA_W-1:0]   pwdata,
	output logic [nsrl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [nsrl_pkg::CNT_W-1:0]    count
);
	import nsrl_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_IDX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (wr_en) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IDX_COUNT: prdata = DATA_W'(count_q);
			default:       prdata = '0;
		endcase
	end

	assign count = count_q;

endmodule

`default_nettype wire

@@ rtl/nearest_seed_region_labeler_top.sv @@
// Throughput: one item per cycle unless a held output result stalls the pipeline.
// Each seed slot is a two-stage cell, square then compare.
// A held output result freezes the whole pipeline; loads pass through and yield no result.
// Reset clears every valid bit and sets the seed count to 1; seed contents stay undefined.
// ----------------------------------------------------------------------------
// nearest_seed_region_labeler_top
// Brute-force Voronoi labeler: one cell per seed slot in a linear pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_seed_region_labeler_top #(
	parameter int MAX_SEEDS = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  nsrl_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  wire                            out_stall,
	output nsrl_pkg::out_t                 out_data,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [nsrl_pkg::ADDR_W-1:0]    paddr,
	input  wire  [nsrl_pkg::DATA_W-1:0]    pwdata,
	output logic [nsrl_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import nsrl_pkg::*;

	pipe_t            chain [0:MAX_SEEDS];
	logic             adv;
	logic [CNT_W-1:0] count;
	pipe_t            last;

	nsrl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.count   (count)
	);

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign chain[0].valid       = in_valid;
	assign chain[0].func        = in_data.func;
	assign chain[0].slot        = in_data.slot;
	assign chain[0].pos_x       = in_data.pos_x;
	assign chain[0].pos_y       = in_data.pos_y;
	assign chain[0].region      = in_data.seed_region;
	assign chain[0].best_dist   = '0;
	assign chain[0].best_region = '0;

	for (genvar k = 0; k < MAX_SEEDS; k++) begin : g_cell
		nsrl_cell #(.K(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.count    (count),
			.pipe_in  (chain[k]),
			.pipe_out (chain[k+1])
		);
	end

	assign last = chain[MAX_SEEDS];

	assign out_valid           = last.valid && (last.func == FUNC_QUERY);
	assign out_data.region_out = last.best_region;
	assign out_data.pixel_x    = last.pos_x;
	assign out_data.pixel_y    = last.pos_y;

endmodule

`default_nettype wire

@@ rtl/nsrl_chk.sv @@
// ----------------------------------------------------------------------------
// nsrl_chk
// Port checker for the nearest-seed region labeler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_seed_region_labeler_top_assert.svh"

module nsrl_chk (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            in_valid,
	input wire                            in_stall,
	input nsrl_pkg::in_t                  in_data,
	input wire                            out_valid,
	input wire                            out_stall,
	input nsrl_pkg::out_t                 out_data,
	input wire                            psel,
	input wire                            penable,
	input wire                            pwrite,
	input wire  [nsrl_pkg::ADDR_W-1:0]    paddr,
	input wire  [nsrl_pkg::DATA_W-1:0]    pwdata,
	input wire  [nsrl_pkg::DATA_W-1:0]    prdata,
	input wire                            pready
);
	import nsrl_pkg::*;

	`NSRL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data), "held result changed")

	`NSRL_ASSERT_NOW(a_in_stall, clk, arst_n, 1'b1,
		in_stall == (out_valid && out_stall), "input stall not tied to held result")

	`NSRL_ASSERT_NEXT(a_cnt_rd, clk, arst_n,
		psel && penable && pwrite && pready && (paddr[2] == REG_IDX_COUNT),
		(paddr[2] != REG_IDX_COUNT) || (prdata == DATA_W'($past(pwdata[CNT_W-1:0]))),
		"count register readback mismatch")

endmodule

bind nearest_seed_region_labeler_top nsrl_chk u_chk (.*);

`default_nettype wire
